// ----- rtl/knp_pkg.sv -----
`timescale 1ns / 1ps
// knp_pkg: constants, payload structs and controller states for k_nearest_point_select.
// Used by knp_cell, k_nearest_point_select and the testbench; knp_ram does not use it. Depends on nothing.
package knp_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int MAX_NEIGHBORS = 8;
    localparam int COORD_BITS    = 18;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int NB_W    = $clog2(MAX_NEIGHBORS + 1);
    localparam int NSEL_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = SQ_W + 1;
    localparam int POINT_W = 2 * COORD_BITS;

    localparam int OP_W       = 2;
    localparam int LIMIT_W    = 4;
    localparam int SAME_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAME_POINT_LIMIT = 2'd1;

    localparam logic [LIMIT_W-1:0] NEIGHBOR_LIMIT_RESET = 4'd4;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] neighbor_x;
        logic [COORD_BITS-1:0] neighbor_y;
        logic [IDX_W-1:0]      neighbor_index;
        logic                  found;
        logic                  short_list;
        logic                  last;
    } t_out_item;

    // what one sorting cell shows its right-hand neighbor
    typedef struct packed {
        logic              less;
        logic              valid;
        logic [DIST_W-1:0] dist_sq;
        logic [IDX_W-1:0]  idx;
    } t_link;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

endpackage

// ----- rtl/knp_ram.sv -----
`timescale 1ns / 1ps
// knp_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module knp_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/knp_cell.sv -----
`timescale 1ns / 1ps
// knp_cell: one slot of the sorted nearest-point list (insertion chain).
// Depends on knp_pkg for t_link and widths.
module knp_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_cand_valid,
    input  logic [knp_pkg::DIST_W-1:0]  i_cand_dist,
    input  logic [knp_pkg::IDX_W-1:0]   i_cand_idx,
    input  knp_pkg::t_link              i_prev,
    output knp_pkg::t_link              o_link
);

    logic                       r_valid;
    logic [knp_pkg::DIST_W-1:0] r_dist;
    logic [knp_pkg::IDX_W-1:0]  r_idx;
    logic                       w_less;

    // strict compare: an equal distance lands behind the earlier point
    assign w_less = !r_valid || (i_cand_dist < r_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_cand_valid) begin
            if (i_prev.less) begin
                r_valid <= i_prev.valid;
            end else if (w_less) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cand_valid) begin
            if (i_prev.less) begin
                r_dist <= i_prev.dist_sq;
                r_idx  <= i_prev.idx;
            end else if (w_less) begin
                r_dist <= i_cand_dist;
                r_idx  <= i_cand_idx;
            end
        end
    end

    assign o_link.less    = w_less;
    assign o_link.valid   = r_valid;
    assign o_link.dist_sq = r_dist;
    assign o_link.idx     = r_idx;

endmodule

// ----- rtl/k_nearest_point_select.sv -----
`timescale 1ns / 1ps
// k_nearest_point_select: brute-force k-nearest search over a 2D point store.
// Depends on knp_pkg, knp_ram (point store) and knp_cell (sorted list chain).
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A query scans the store with one store read per point through a four-stage distance
// pipeline into the cell chain, then reads each result item back from the point store
// (a read state and a load state per item); scan and result reads share its read port.
// Reset is synchronous and empties the store by zeroing the fill count; no clearing pass.
// A stalled output holds its item; loading the next result item waits for the output register.
module k_nearest_point_select (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  knp_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output knp_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [knp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [knp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int C = knp_pkg::COORD_BITS;
    localparam int N = knp_pkg::MAX_NEIGHBORS;

    knp_pkg::t_state r_state, n_state;

    logic [knp_pkg::LIMIT_W-1:0] r_neighbor_limit;
    logic [knp_pkg::SAME_W-1:0]  r_same_limit;
    logic [knp_pkg::CNT_W-1:0]   r_count;
    logic [knp_pkg::CNT_W-1:0]   r_scan;
    logic [C-1:0]                r_qx, r_qy;
    logic [knp_pkg::NB_W-1:0]    r_lim;
    logic [knp_pkg::NB_W-1:0]    r_n;
    logic [knp_pkg::NB_W-1:0]    r_emit;

    // distance pipeline
    logic                        r_v0, r_va, r_vb, r_vc;
    logic [knp_pkg::IDX_W-1:0]   r_i0, r_ia, r_ib, r_ic;
    logic [C-1:0]                r_dx, r_dy;
    logic [knp_pkg::SQ_W-1:0]    r_sx, r_sy;
    logic [knp_pkg::DIST_W-1:0]  r_d;
    logic                        r_qual;

    logic                        r_out_valid;
    knp_pkg::t_out_item          r_out;

    logic                        w_in_acc, w_out_free, w_pipe_empty, w_last_scan, w_last_emit;
    logic                        w_rd_en, w_wr_en;
    logic [knp_pkg::IDX_W-1:0]   w_rd_addr;
    logic [knp_pkg::POINT_W-1:0] w_rd_data;
    logic [C-1:0]                w_sx, w_sy;
    logic [knp_pkg::NB_W-1:0]    w_lim, w_cnt, w_n;
    logic [N-1:0]                w_valids;
    knp_pkg::t_link              w_link [N];
    knp_pkg::t_link              w_prev [N];

    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_pipe_empty = !r_v0 && !r_va && !r_vb && !r_vc;
    assign w_last_scan  = (r_scan + 1'b1) == r_count;
    assign w_last_emit  = (r_n == '0) || ((r_emit + 1'b1) == r_n);
    assign w_sx         = w_rd_data[knp_pkg::POINT_W-1:C];
    assign w_sy         = w_rd_data[C-1:0];
    assign o_cfg_ready  = 1'b1;

    // limit 0 acts as 1, above the list length it saturates
    always_comb begin
        if (r_neighbor_limit == '0) begin
            w_lim = knp_pkg::NB_W'(1);
        end else if (knp_pkg::NB_W'(r_neighbor_limit) > knp_pkg::NB_W'(N)) begin
            w_lim = knp_pkg::NB_W'(N);
        end else begin
            w_lim = knp_pkg::NB_W'(r_neighbor_limit);
        end
    end

    assign w_wr_en = w_in_acc && (i_in_data.operation == knp_pkg::OP_ADD)
                     && (r_count < knp_pkg::CNT_W'(knp_pkg::MAX_POINTS));

    knp_ram #(
        .WIDTH(knp_pkg::POINT_W),
        .DEPTH(knp_pkg::MAX_POINTS)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[knp_pkg::IDX_W-1:0]),
        .i_wr_data({i_in_data.point_x, i_in_data.point_y}),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // sorted chain, nearest in cell 0
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g] = '0;
            end else begin : g_body
                assign w_prev[g] = w_link[g-1];
            end
            knp_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_clear     (w_in_acc && (i_in_data.operation == knp_pkg::OP_QUERY)),
                .i_cand_valid(r_vc && r_qual),
                .i_cand_dist (r_d),
                .i_cand_idx  (r_ic),
                .i_prev      (w_prev[g]),
                .o_link      (w_link[g])
            );
            assign w_valids[g] = w_link[g].valid;
        end
    endgenerate

    assign w_cnt = knp_pkg::NB_W'($countones(w_valids));
    assign w_n   = (w_cnt < r_lim) ? w_cnt : r_lim;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            knp_pkg::S_IDLE: begin
                if (w_in_acc && (i_in_data.operation == knp_pkg::OP_QUERY)) begin
                    n_state = (r_count == '0) ? knp_pkg::S_DRAIN : knp_pkg::S_SCAN;
                end
            end
            knp_pkg::S_SCAN: begin
                if (w_last_scan) begin
                    n_state = knp_pkg::S_DRAIN;
                end
            end
            knp_pkg::S_DRAIN: begin
                if (w_pipe_empty) begin
                    n_state = knp_pkg::S_EMIT_RD;
                end
            end
            knp_pkg::S_EMIT_RD: begin
                n_state = knp_pkg::S_EMIT_LD;
            end
            knp_pkg::S_EMIT_LD: begin
                if (w_out_free) begin
                    n_state = w_last_emit ? knp_pkg::S_IDLE : knp_pkg::S_EMIT_RD;
                end
            end
            default: begin
                n_state = knp_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_in_stall = 1'b1;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_scan[knp_pkg::IDX_W-1:0];
        case (r_state)
            knp_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            knp_pkg::S_SCAN: begin
                w_rd_en = 1'b1;
            end
            knp_pkg::S_EMIT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_link[r_emit[knp_pkg::NSEL_W-1:0]].idx;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= knp_pkg::S_IDLE;
            r_neighbor_limit <= knp_pkg::NEIGHBOR_LIMIT_RESET;
            r_same_limit     <= '0;
            r_count          <= '0;
            r_scan           <= '0;
            r_emit           <= '0;
            r_v0             <= 1'b0;
            r_va             <= 1'b0;
            r_vb             <= 1'b0;
            r_vc             <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == knp_pkg::REG_NEIGHBOR_LIMIT) begin
                    r_neighbor_limit <= i_cfg_data[knp_pkg::LIMIT_W-1:0];
                end else if (i_cfg_index == knp_pkg::REG_SAME_POINT_LIMIT) begin
                    r_same_limit <= i_cfg_data[knp_pkg::SAME_W-1:0];
                end
            end
            if (w_wr_en) begin
                r_count <= r_count + 1'b1;
            end else if (w_in_acc && (i_in_data.operation == knp_pkg::OP_CLEAR)) begin
                r_count <= '0;
            end
            if (w_in_acc) begin
                r_scan <= '0;
                r_emit <= '0;
            end else if (r_state == knp_pkg::S_SCAN) begin
                r_scan <= r_scan + 1'b1;
            end else if ((r_state == knp_pkg::S_EMIT_LD) && w_out_free) begin
                r_emit <= r_emit + 1'b1;
            end
            r_v0 <= (r_state == knp_pkg::S_SCAN);
            r_va <= r_v0;
            r_vb <= r_va;
            r_vc <= r_vb;
            if ((r_state == knp_pkg::S_EMIT_LD) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.operation == knp_pkg::OP_QUERY)) begin
            r_qx  <= i_in_data.point_x;
            r_qy  <= i_in_data.point_y;
            r_lim <= w_lim;
        end
        if ((r_state == knp_pkg::S_DRAIN) && w_pipe_empty) begin
            r_n <= w_n;
        end
        r_i0   <= r_scan[knp_pkg::IDX_W-1:0];
        r_ia   <= r_i0;
        r_dx   <= (w_sx >= r_qx) ? (w_sx - r_qx) : (r_qx - w_sx);
        r_dy   <= (w_sy >= r_qy) ? (w_sy - r_qy) : (r_qy - w_sy);
        r_ib   <= r_ia;
        r_sx   <= knp_pkg::SQ_W'(r_dx) * knp_pkg::SQ_W'(r_dx);
        r_sy   <= knp_pkg::SQ_W'(r_dy) * knp_pkg::SQ_W'(r_dy);
        r_ic   <= r_ib;
        r_d    <= knp_pkg::DIST_W'(r_sx) + knp_pkg::DIST_W'(r_sy);
        r_qual <= (knp_pkg::DIST_W'(r_sx) + knp_pkg::DIST_W'(r_sy))
                  > knp_pkg::DIST_W'(r_same_limit);
        if ((r_state == knp_pkg::S_EMIT_LD) && w_out_free) begin
            if (r_n == '0) begin
                r_out.neighbor_x     <= '0;
                r_out.neighbor_y     <= '0;
                r_out.neighbor_index <= '0;
                r_out.found          <= 1'b0;
            end else begin
                r_out.neighbor_x     <= w_sx;
                r_out.neighbor_y     <= w_sy;
                r_out.neighbor_index <= w_link[r_emit[knp_pkg::NSEL_W-1:0]].idx;
                r_out.found          <= 1'b1;
            end
            r_out.short_list <= (r_n < r_lim);
            r_out.last       <= w_last_emit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_notfound_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.last && o_out_data.short_list))
        else $error("empty result is not the final short item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= knp_pkg::CNT_W'(knp_pkg::MAX_POINTS))
        else $error("point count past store size");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valids & (w_valids + 1'b1)) == '0))
        else $error("sorted list has a gap");

    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == knp_pkg::S_IDLE) |-> w_pipe_empty)
        else $error("distance pipeline busy while idle");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == knp_pkg::S_EMIT_LD && r_n != '0) |-> (r_emit < r_n))
        else $error("result counter past list length");

endmodule

// ----- dv/knp_neighbor_check.sv -----
`timescale 1ns / 1ps
// knp_neighbor_check: watches the channels of k_nearest_point_select, keeps its own point
// store and register copies, predicts each query's neighbor list and compares results.
// Depends on knp_pkg for the payload structs, sizes, operation and register codes.
module knp_neighbor_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  knp_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  knp_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [knp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [knp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    logic [knp_pkg::COORD_BITS-1:0] store_x [knp_pkg::MAX_POINTS];
    logic [knp_pkg::COORD_BITS-1:0] store_y [knp_pkg::MAX_POINTS];
    int                             stored_points;
    logic [knp_pkg::LIMIT_W-1:0]    neighbor_limit;
    logic [knp_pkg::SAME_W-1:0]     same_point_limit;
    knp_pkg::t_out_item             expected_neighbors [$];
    int                             fail_count = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    function automatic logic [knp_pkg::DIST_W-1:0] squared_distance(
        logic [knp_pkg::COORD_BITS-1:0] ax, logic [knp_pkg::COORD_BITS-1:0] ay,
        logic [knp_pkg::COORD_BITS-1:0] bx, logic [knp_pkg::COORD_BITS-1:0] by);
        logic [knp_pkg::COORD_BITS-1:0] dx;
        logic [knp_pkg::COORD_BITS-1:0] dy;
        dx = (ax >= bx) ? ax - bx : bx - ax;
        dy = (ay >= by) ? ay - by : by - ay;
        return knp_pkg::DIST_W'(dx) * knp_pkg::DIST_W'(dx)
             + knp_pkg::DIST_W'(dy) * knp_pkg::DIST_W'(dy);
    endfunction

    // Sorted insertion keeps the earlier point ahead on equal distance.
    task automatic predict_nearest(logic [knp_pkg::COORD_BITS-1:0] qx,
                                   logic [knp_pkg::COORD_BITS-1:0] qy);
        logic [knp_pkg::DIST_W-1:0] rank_dist [knp_pkg::MAX_NEIGHBORS];
        int                         rank_idx  [knp_pkg::MAX_NEIGHBORS];
        logic [knp_pkg::DIST_W-1:0] d;
        knp_pkg::t_out_item         res;
        int                         keep;
        int                         filled;
        int                         pos;
        int                         k;
        keep = (neighbor_limit == 0) ? 1 :
               (neighbor_limit > knp_pkg::MAX_NEIGHBORS) ? knp_pkg::MAX_NEIGHBORS
                                                         : int'(neighbor_limit);
        filled = 0;
        for (int i = 0; i < stored_points; i++) begin
            d = squared_distance(store_x[i], store_y[i], qx, qy);
            if (d > knp_pkg::DIST_W'(same_point_limit)) begin
                pos = 0;
                while (pos < filled && rank_dist[pos] <= d) pos++;
                if (pos < keep) begin
                    k = (filled < keep) ? filled : keep - 1;
                    while (k > pos) begin
                        rank_dist[k] = rank_dist[k-1];
                        rank_idx[k]  = rank_idx[k-1];
                        k--;
                    end
                    rank_dist[pos] = d;
                    rank_idx[pos]  = i;
                    if (filled < keep) filled++;
                end
            end
        end
        if (filled == 0) begin
            res = '0;
            res.short_list = 1'b1;
            res.last       = 1'b1;
            expected_neighbors.insert(expected_neighbors.size(), res);
        end else begin
            for (int j = 0; j < filled; j++) begin
                res.neighbor_x     = store_x[rank_idx[j]];
                res.neighbor_y     = store_y[rank_idx[j]];
                res.neighbor_index = knp_pkg::IDX_W'(rank_idx[j]);
                res.found          = 1'b1;
                res.short_list     = (filled < keep);
                res.last           = (j == filled - 1);
                expected_neighbors.insert(expected_neighbors.size(), res);
            end
        end
    endtask

    always @(posedge i_clk) begin
        knp_pkg::t_out_item want;
        if (!i_rst_n) begin
            stored_points    = 0;
            neighbor_limit   = knp_pkg::NEIGHBOR_LIMIT_RESET;
            same_point_limit = '0;
            expected_neighbors.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_neighbors.size() == 0) begin
                    report_mismatch("result with no query waiting", i_out_data.neighbor_index, 0);
                end else begin
                    want = expected_neighbors.pop_front();
                    check_field("neighbor_x", i_out_data.neighbor_x, want.neighbor_x);
                    check_field("neighbor_y", i_out_data.neighbor_y, want.neighbor_y);
                    check_field("neighbor_index", i_out_data.neighbor_index,
                                want.neighbor_index);
                    check_field("found", i_out_data.found, want.found);
                    check_field("short_list", i_out_data.short_list, want.short_list);
                    check_field("last", i_out_data.last, want.last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_in_data.operation)
                    knp_pkg::OP_ADD: begin
                        // full store drops the add
                        if (stored_points < knp_pkg::MAX_POINTS) begin
                            store_x[stored_points] = i_in_data.point_x;
                            store_y[stored_points] = i_in_data.point_y;
                            stored_points++;
                        end
                    end
                    knp_pkg::OP_QUERY: predict_nearest(i_in_data.point_x, i_in_data.point_y);
                    knp_pkg::OP_CLEAR: stored_points = 0;
                    default: ;
                endcase
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    knp_pkg::REG_NEIGHBOR_LIMIT:
                        neighbor_limit = i_cfg_data[knp_pkg::LIMIT_W-1:0];
                    knp_pkg::REG_SAME_POINT_LIMIT:
                        same_point_limit = i_cfg_data[knp_pkg::SAME_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_neighbors.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- dv/k_nearest_point_select_test.sv -----
`timescale 1ns / 1ps
// k_nearest_point_select_test: drives point adds, clears and queries with random gaps,
// output stalls and register changes; knp_neighbor_check does the checking.
// Depends on knp_pkg, knp_neighbor_check and the k_nearest_point_select RTL.
module k_nearest_point_select_test;

    localparam logic [knp_pkg::OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [knp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [knp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int COORD_MAX     = (1 << knp_pkg::COORD_BITS) - 1;
    localparam int IDLE_LIMIT    = 6000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 64;
    localparam int TARGET_ITEMS  = 350;
    localparam int QUIET_AFTER   = 300;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    knp_pkg::t_in_item              in_data   = '0;
    logic                           out_valid;
    logic                           out_stall;
    knp_pkg::t_out_item             out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [knp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [knp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic [4:0] stall_left  = '0;
    logic       heavy_stall = 1'b1;
    logic       quiet       = 1'b0;
    logic       gappy       = 1'b1;
    int         items_sent  = 0;
    int         idle_cycles = 0;
    int         fail_count;
    int         pending;

    always #1 clk = ~clk;

    k_nearest_point_select uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    knp_neighbor_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver stalls in bursts; heavy/calm mode flips now and then
    always @(negedge clk) begin
        if ($urandom_range(0, 255) == 0) heavy_stall <= ~heavy_stall;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1'b1;
        end else if (!quiet && heavy_stall && $urandom_range(0, 3) == 0) begin
            stall_left <= 5'($urandom_range(1, 16));
        end
    end
    assign out_stall = (stall_left != 0);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic knp_pkg::t_in_item make_item(logic [knp_pkg::OP_W-1:0] op,
                                                    int unsigned x, int unsigned y);
        knp_pkg::t_in_item it;
        it.operation = op;
        it.point_x   = knp_pkg::COORD_BITS'(x);
        it.point_y   = knp_pkg::COORD_BITS'(y);
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push(knp_pkg::t_in_item it);
        in_data  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send(logic [knp_pkg::OP_W-1:0] op, int unsigned x, int unsigned y);
        if (gappy && !quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        push(make_item(op, x, y));
        if (op != OP_UNUSED) items_sent++;
    endtask

    // let every query finish before touching the registers
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [knp_pkg::CFG_IDX_W-1:0] idx,
                             logic [knp_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_config();
        logic [knp_pkg::LIMIT_W-1:0]    lim;
        logic [knp_pkg::CFG_DATA_W-1:0] same;
        case ($urandom_range(0, 4))
            0: lim = 4'd0;
            1: lim = 4'd1;
            2: lim = 4'd8;
            3: lim = 4'd15;
            default: lim = knp_pkg::LIMIT_W'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 3))
            0: same = 8'd0;
            1: same = 8'd255;
            2: same = knp_pkg::CFG_DATA_W'($urandom_range(1, 40));
            default: same = knp_pkg::CFG_DATA_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 1)) begin
            write_reg(knp_pkg::REG_NEIGHBOR_LIMIT, {4'($urandom), lim});
            write_reg(knp_pkg::REG_SAME_POINT_LIMIT, same);
        end else begin
            write_reg(knp_pkg::REG_SAME_POINT_LIMIT, same);
            write_reg(knp_pkg::REG_NEIGHBOR_LIMIT, {4'($urandom), lim});
        end
        if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      knp_pkg::CFG_DATA_W'($urandom));
        end
    endtask

    // tight grids give distance ties, clusters give same-point skips
    function automatic int unsigned pick_coord(int mode, int unsigned base);
        case (mode)
            0: return $urandom_range(0, COORD_MAX);
            1: return base + 4 * $urandom_range(0, 7);
            2: return base + $urandom_range(0, 40);
            default: return $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                 : COORD_MAX - $urandom_range(0, 7);
        endcase
    endfunction

    function automatic int unsigned nudge(int unsigned c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    // mostly clear, fill, query; now and then no clear or an unused opcode
    task automatic run_sequence();
        int unsigned xs [64];
        int unsigned ys [64];
        int          mode;
        int          n_points;
        int          n_queries;
        int          k;
        int unsigned bx;
        int unsigned by;
        int unsigned qx;
        int unsigned qy;
        mode = $urandom_range(0, 3);
        bx   = $urandom_range(0, COORD_MAX - 64);
        by   = $urandom_range(0, COORD_MAX - 64);
        if ($urandom_range(0, 9) != 0) begin
            send(knp_pkg::OP_CLEAR, $urandom_range(0, COORD_MAX),
                 $urandom_range(0, COORD_MAX));
        end
        n_points = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                               : $urandom_range(0, 12);
        for (int j = 0; j < n_points; j++) begin
            xs[j] = pick_coord(mode, bx);
            ys[j] = pick_coord(mode, by);
            send(knp_pkg::OP_ADD, xs[j], ys[j]);
        end
        n_queries = $urandom_range(1, 4);
        for (int j = 0; j < n_queries; j++) begin
            if ($urandom_range(0, 15) == 0) begin
                send(OP_UNUSED, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end
            if (n_points != 0 && $urandom_range(0, 1)) begin
                k  = $urandom_range(0, n_points - 1);
                qx = nudge(xs[k]);
                qy = nudge(ys[k]);
            end else begin
                qx = pick_coord(mode, bx);
                qy = pick_coord(mode, by);
            end
            send(knp_pkg::OP_QUERY, qx, qy);
        end
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: limit 4, same-point limit 0
        send(knp_pkg::OP_QUERY, 0, 0);              // empty store
        send(knp_pkg::OP_ADD, 0, 0);
        send(knp_pkg::OP_ADD, COORD_MAX, COORD_MAX);
        send(knp_pkg::OP_ADD, 0, COORD_MAX);
        send(knp_pkg::OP_ADD, COORD_MAX, 0);
        send(knp_pkg::OP_ADD, 0, 0);
        send(knp_pkg::OP_ADD, 100, 100);
        send(OP_UNUSED, COORD_MAX, COORD_MAX);
        send(knp_pkg::OP_QUERY, 0, 0);              // zero-distance skip, tie on corners
        send(knp_pkg::OP_QUERY, COORD_MAX, COORD_MAX);
        send(knp_pkg::OP_QUERY, 131072, 131072);
        settle();
        write_reg(knp_pkg::REG_NEIGHBOR_LIMIT, 8'd0);        // acts as one
        write_reg(knp_pkg::REG_SAME_POINT_LIMIT, 8'd255);
        send(knp_pkg::OP_QUERY, 5, 5);
        send(knp_pkg::OP_QUERY, 110, 100);
        settle();
        write_reg(knp_pkg::REG_NEIGHBOR_LIMIT, 8'hFF);       // clamps to the max neighbor count
        send(knp_pkg::OP_QUERY, 1, 1);              // short list
        for (int j = 0; j < 8; j++) send(knp_pkg::OP_ADD, 1000 + 3 * j, 2000);
        send(knp_pkg::OP_QUERY, 1000, 2000);
        send(knp_pkg::OP_CLEAR, 0, 0);
        send(knp_pkg::OP_QUERY, COORD_MAX, 0);      // nothing left

        while (items_sent < TARGET_ITEMS) begin
            settle();
            random_config();
            gappy = ($urandom_range(0, 3) != 0);
            if (items_sent >= QUIET_AFTER) quiet <= 1'b1;
            repeat ($urandom_range(2, 5)) run_sequence();
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/knp_pkg.sv
rtl/knp_ram.sv
rtl/knp_cell.sv
rtl/k_nearest_point_select.sv
dv/knp_neighbor_check.sv
dv/k_nearest_point_select_test.sv
